@@ hdl/elx_pkg.sv @@
package elx_pkg;

  // Output position fields are always 16 bits; internal counters may be wider
  // or narrower and are cut or zero-extended to this width.
  localparam int OutPosW   = 16;
  localparam int PosBitsDef = 16;

  // Record queue between the lexer step and the result channel.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Characters with a special role in the grammar.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Command codes of the input beat.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Record types of the result beat.
  localparam logic REC_TEXT  = 1'b0;
  localparam logic REC_TOKEN = 1'b1;

  typedef enum logic [4:0] {
    KIND_NAME   = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_PLUS   = 5'd2,
    KIND_MINUS  = 5'd3,
    KIND_STAR   = 5'd4,
    KIND_SLASH  = 5'd5,
    KIND_EQ     = 5'd6,
    KIND_LT     = 5'd7,
    KIND_GT     = 5'd8,
    KIND_LP     = 5'd9,
    KIND_RP     = 5'd10,
    KIND_COMMA  = 5'd11,
    KIND_COLON  = 5'd12,
    KIND_NL     = 5'd13,
    KIND_LB     = 5'd14,
    KIND_RB     = 5'd15,
    KIND_EOF    = 5'd16
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_MINUS   = 3'd4,
    MODE_COMMENT = 3'd5
  } lex_mode_t;

  // Lexer control state, everything except the position counters.
  typedef struct packed {
    lex_mode_t mode;
    tok_kind_t prev_kind;
    logic      seen_token;
  } lex_ctl_t;

  localparam lex_ctl_t CTL_RESET = '{mode: MODE_IDLE, prev_kind: KIND_NAME, seen_token: 1'b0};

  // One result record.
  typedef struct packed {
    logic                record_type;
    tok_kind_t           token_kind;
    logic [7:0]          text_byte;
    logic [OutPosW-1:0]  tok_line;
    logic [OutPosW-1:0]  tok_col;
    logic                last;
  } lex_rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  // Single-character operator tokens: hit flag and kind.
  function automatic logic is_single(input logic [7:0] c);
    case (c)
      8'h2B, 8'h2A, 8'h3D, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    case (c)
      8'h2B:   return KIND_PLUS;
      8'h2A:   return KIND_STAR;
      8'h3D:   return KIND_EQ;
      8'h3C:   return KIND_LT;
      8'h3E:   return KIND_GT;
      8'h28:   return KIND_LP;
      8'h29:   return KIND_RP;
      8'h7B:   return KIND_LB;
      8'h7D:   return KIND_RB;
      8'h2C:   return KIND_COMMA;
      8'h3A:   return KIND_COLON;
      default: return KIND_NAME;
    endcase
  endfunction

  // A minus may open a signed number only at the start or after these tokens.
  function automatic logic minus_may_sign(input lex_ctl_t ctl);
    if (!ctl.seen_token) begin
      return 1'b1;
    end
    case (ctl.prev_kind)
      KIND_EQ, KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_LP, KIND_COMMA, KIND_NL:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

endpackage

@@ hdl/elx_in_if.sv @@
interface elx_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_byte;

  modport source (output valid, output cmd, output char_byte, input ready);
  modport sink (input valid, input cmd, input char_byte, output ready);
endinterface

@@ hdl/elx_out_if.sv @@
interface elx_out_if;
  logic        valid;
  logic        ready;
  logic        record_type;
  logic [4:0]  token_kind;
  logic [7:0]  text_byte;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic        last;

  modport source (output valid, output record_type, output token_kind, output text_byte,
                  output tok_line, output tok_col, output last, input ready);
  modport sink (input valid, input record_type, input token_kind, input text_byte,
                input tok_line, input tok_col, input last, output ready);
endinterface

@@ hdl/elx_step.sv @@
module elx_step
  import elx_pkg::*;
#(
  parameter int POS_BITS = PosBitsDef
) (
  input  logic                cmd,
  input  logic [7:0]          char_byte,
  input  lex_ctl_t            ctl,
  input  logic [POS_BITS-1:0] cur_line,
  input  logic [POS_BITS-1:0] cur_col,
  input  logic [POS_BITS-1:0] start_col,
  output lex_ctl_t            ctl_nxt,
  output logic [POS_BITS-1:0] line_nxt,
  output logic [POS_BITS-1:0] col_nxt,
  output logic [POS_BITS-1:0] scol_nxt,
  output logic [1:0]          rec_cnt,
  output lex_rec_t            rec0,
  output lex_rec_t            rec1
);

  localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] PosMax = '1;

  function automatic lex_rec_t mk_rec(input logic rt, input tok_kind_t kind,
                                      input logic [7:0] b, input logic [POS_BITS-1:0] ln,
                                      input logic [POS_BITS-1:0] cl);
    lex_rec_t r;
    r.record_type = rt;
    r.token_kind  = kind;
    r.text_byte   = b;
    r.tok_line    = OutPosW'(ln);
    r.tok_col     = OutPosW'(cl);
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
    return (p == PosMax) ? p : p + PosOne;
  endfunction

  lex_rec_t   recs [2];
  logic [1:0] n;
  logic       do_idle;

  // One source beat: mode-specific handling first, then the idle dispatch.
  always_comb begin
    ctl_nxt  = ctl;
    line_nxt = cur_line;
    col_nxt  = cur_col;
    scol_nxt = start_col;
    n        = 2'd0;
    do_idle  = 1'b0;
    recs[0]  = '0;
    recs[1]  = '0;

    if (cmd == CMD_END) begin
      // Flush an open token, then EOF; the lexer starts fresh afterwards.
      case (ctl.mode)
        MODE_NAME, MODE_NUMBER: begin
          recs[n[0]] = mk_rec(REC_TOKEN,
                              (ctl.mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER,
                              8'd0, line_nxt, scol_nxt);
          n = n + 2'd1;
        end
        MODE_SLASH, MODE_MINUS: begin
          recs[n[0]] = mk_rec(REC_TOKEN,
                              (ctl.mode == MODE_SLASH) ? KIND_SLASH : KIND_MINUS,
                              8'd0, line_nxt, scol_nxt);
          n = n + 2'd1;
          col_nxt = sat_inc(col_nxt);
        end
        default: begin
        end
      endcase
      recs[n[0]] = mk_rec(REC_TOKEN, KIND_EOF, 8'd0, line_nxt, col_nxt);
      n = n + 2'd1;
      ctl_nxt  = CTL_RESET;
      line_nxt = PosOne;
      col_nxt  = PosOne;
      scol_nxt = PosOne;
    end else begin
      case (ctl.mode)
        MODE_NAME, MODE_NUMBER: begin
          if ((ctl.mode == MODE_NAME) ? is_name_char(char_byte) : is_num_char(char_byte)) begin
            recs[n[0]] = mk_rec(REC_TEXT,
                                (ctl.mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER,
                                char_byte, line_nxt, scol_nxt);
            n = n + 2'd1;
            col_nxt = sat_inc(col_nxt);
          end else begin
            recs[n[0]] = mk_rec(REC_TOKEN,
                                (ctl.mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER,
                                8'd0, line_nxt, scol_nxt);
            n = n + 2'd1;
            ctl_nxt.prev_kind  = (ctl.mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER;
            ctl_nxt.seen_token = 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_byte == CH_SLASH) begin
            ctl_nxt.mode = MODE_COMMENT;
          end else begin
            recs[n[0]] = mk_rec(REC_TOKEN, KIND_SLASH, 8'd0, line_nxt, scol_nxt);
            n = n + 2'd1;
            ctl_nxt.prev_kind  = KIND_SLASH;
            ctl_nxt.seen_token = 1'b1;
            col_nxt = sat_inc(col_nxt);
            do_idle = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (is_num_char(char_byte) && minus_may_sign(ctl)) begin
            // Signed number: the minus and this byte are both text.
            ctl_nxt.mode = MODE_NUMBER;
            recs[0] = mk_rec(REC_TEXT, KIND_NUMBER, CH_MINUS, line_nxt, scol_nxt);
            recs[1] = mk_rec(REC_TEXT, KIND_NUMBER, char_byte, line_nxt, scol_nxt);
            n = 2'd2;
            col_nxt = sat_inc(sat_inc(col_nxt));
          end else begin
            recs[n[0]] = mk_rec(REC_TOKEN, KIND_MINUS, 8'd0, line_nxt, scol_nxt);
            n = n + 2'd1;
            ctl_nxt.prev_kind  = KIND_MINUS;
            ctl_nxt.seen_token = 1'b1;
            col_nxt = sat_inc(col_nxt);
            do_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          // Comment bytes are dropped with the column frozen; newline ends it.
          do_idle = (char_byte == CH_LF);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Dispatch of a byte seen with no token open.
      if (do_idle) begin
        ctl_nxt.mode = MODE_IDLE;
        if (char_byte == CH_SLASH) begin
          ctl_nxt.mode = MODE_SLASH;
          scol_nxt = col_nxt;
        end else if (char_byte == CH_MINUS) begin
          ctl_nxt.mode = MODE_MINUS;
          scol_nxt = col_nxt;
        end else if (char_byte == CH_LF) begin
          recs[n[0]] = mk_rec(REC_TOKEN, KIND_NL, 8'd0, line_nxt, col_nxt);
          n = n + 2'd1;
          ctl_nxt.prev_kind  = KIND_NL;
          ctl_nxt.seen_token = 1'b1;
          line_nxt = sat_inc(line_nxt);
          col_nxt  = PosOne;
        end else if (is_single(char_byte)) begin
          recs[n[0]] = mk_rec(REC_TOKEN, single_kind(char_byte), 8'd0, line_nxt, col_nxt);
          n = n + 2'd1;
          ctl_nxt.prev_kind  = single_kind(char_byte);
          ctl_nxt.seen_token = 1'b1;
          col_nxt = sat_inc(col_nxt);
        end else if (is_num_char(char_byte)) begin
          ctl_nxt.mode = MODE_NUMBER;
          scol_nxt = col_nxt;
          recs[n[0]] = mk_rec(REC_TEXT, KIND_NUMBER, char_byte, line_nxt, col_nxt);
          n = n + 2'd1;
          col_nxt = sat_inc(col_nxt);
        end else if (is_alpha(char_byte) || (char_byte == CH_USCORE)) begin
          ctl_nxt.mode = MODE_NAME;
          scol_nxt = col_nxt;
          recs[n[0]] = mk_rec(REC_TEXT, KIND_NAME, char_byte, line_nxt, col_nxt);
          n = n + 2'd1;
          col_nxt = sat_inc(col_nxt);
        end else begin
          // Whitespace and unknown bytes only move the column.
          col_nxt = sat_inc(col_nxt);
        end
      end
    end

    // Flag the final record of this beat.
    if (n == 2'd1) begin
      recs[0].last = 1'b1;
    end else if (n == 2'd2) begin
      recs[1].last = 1'b1;
    end
  end

  assign rec_cnt = n;
  assign rec0    = recs[0];
  assign rec1    = recs[1];

endmodule

@@ hdl/elx_queue.sv @@
module elx_queue
  import elx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  lex_rec_t   push0,
  input  lex_rec_t   push1,
  output logic       room2,
  output logic       pop_valid,
  input  logic       pop_ready,
  output lex_rec_t   pop_rec
);

  lex_rec_t         mem [QDepth];
  logic [QPtrW-1:0] head_r, head_nxt;
  logic [QPtrW-1:0] tail_r, tail_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_rec   = mem[head_r];
  assign room2     = (cnt_r <= QCntW'(QDepth - 2));

  // Pointer and fill count updates.
  always_comb begin
    head_nxt = pop ? head_r + QPtrW'(1) : head_r;
    tail_nxt = tail_r + QPtrW'(push_cnt);
    cnt_nxt  = cnt_r + QCntW'(push_cnt) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Up to two records written per cycle at the tail.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[tail_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[tail_r + QPtrW'(1)] <= push1;
    end
  end

endmodule

@@ hdl/expression_lexer.sv @@
// Streaming lexer: one source byte or end-of-source command per input beat,
// giving text-byte and token records on the result channel. A beat is taken
// into an input register, lexed against the mode, line and column state,
// and its zero to two records go into a four-entry record queue that
// drives the result channel; a beat's first record passes through the
// input register and the queue. Input beats are taken one per cycle as
// long as the queue has room for two more records; with no stall on the
// result channel the sustained rate is one byte per cycle when each byte
// yields at most one record, and the result channel's one record per cycle
// bounds it when beats yield two. Line and column counters are POS_BITS
// wide and saturate; the position fields carry their low 16 bits.
module expression_lexer
  import elx_pkg::*;
#(
  parameter int POS_BITS = PosBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  elx_in_if.sink     in_bus,
  elx_out_if.source  out_bus
);

  localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);

  logic                in_valid_r;
  logic                cmd_r;
  logic [7:0]          byte_r;
  lex_ctl_t            ctl_r, ctl_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;
  logic [POS_BITS-1:0] scol_r, scol_nxt;
  logic [1:0]          rec_cnt;
  lex_rec_t            rec0, rec1, head_rec;
  logic                room2;
  logic                step_go;

  // The held beat is lexed once the queue can take two records.
  assign step_go      = in_valid_r && room2;
  assign in_bus.ready = !in_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      cmd_r  <= in_bus.cmd;
      byte_r <= in_bus.char_byte;
    end
  end

  elx_step #(
    .POS_BITS (POS_BITS)
  ) u_step (
    .cmd       (cmd_r),
    .char_byte (byte_r),
    .ctl       (ctl_r),
    .cur_line  (line_r),
    .cur_col   (col_r),
    .start_col (scol_r),
    .ctl_nxt   (ctl_nxt),
    .line_nxt  (line_nxt),
    .col_nxt   (col_nxt),
    .scol_nxt  (scol_nxt),
    .rec_cnt   (rec_cnt),
    .rec0      (rec0),
    .rec1      (rec1)
  );

  // Lexer state advances once per lexed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= CTL_RESET;
      line_r <= PosOne;
      col_r  <= PosOne;
      scol_r <= PosOne;
    end else if (step_go) begin
      ctl_r  <= ctl_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      scol_r <= scol_nxt;
    end
  end

  elx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (step_go ? rec_cnt : 2'd0),
    .push0     (rec0),
    .push1     (rec1),
    .room2     (room2),
    .pop_valid (out_bus.valid),
    .pop_ready (out_bus.ready),
    .pop_rec   (head_rec)
  );

  // Result beat fields from the queue head.
  assign out_bus.record_type = head_rec.record_type;
  assign out_bus.token_kind  = head_rec.token_kind;
  assign out_bus.text_byte   = head_rec.text_byte;
  assign out_bus.tok_line    = head_rec.tok_line;
  assign out_bus.tok_col     = head_rec.tok_col;
  assign out_bus.last        = head_rec.last;

endmodule
